@@ design/gcts_pkg.sv @@
// ---------------------------------------------------------------------------
// gcts_pkg
// Shared types and constants of the Gaussian-process trajectory sampler.
// ---------------------------------------------------------------------------
`default_nettype none

package gcts_pkg;

	localparam int MAX_STEPS_DEF = 16;

	localparam logic [39:0] NOISE_Q30  = 40'd1073742;
	localparam logic [31:0] EXP_M1_Q30 = 32'd395007542;
	localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
	localparam logic [31:0] Q30_MAX    = 32'h7fff_ffff;
	localparam logic [31:0] Q30_MIN    = 32'h8000_0000;
	localparam logic [47:0] EXP_CUT    = 48'h16_0000;
	localparam logic [3:0]  TAYLOR_N   = 4'd12;

	localparam logic [23:0] SHARP_RST = 24'd65536;
	localparam logic [23:0] SCALE_RST = 24'd65536;
	localparam logic [23:0] DT_RST    = 24'd6554;
	localparam logic [4:0]  STEPS_RST = 5'd16;

	typedef enum logic [1:0] {
		REG_SHARP = 2'd0,
		REG_SCALE = 2'd1,
		REG_DT    = 2'd2,
		REG_STEPS = 2'd3
	} reg_idx_t;

	typedef enum logic {
		OP_BUILD  = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_NPD    = 2'd1,
		STS_NOFACT = 2'd2
	} status_t;

	typedef struct packed {
		logic [23:0] sharp;
		logic [23:0] scale;
		logic [23:0] dt;
		logic [4:0]  steps;
	} cfg_t;

	typedef struct packed {
		logic [31:0] value;
		logic [3:0]  step;
		logic        last;
		status_t     status;
	} res_t;

	typedef struct packed {
		logic        start;
		logic        is_sqrt;
		logic [63:0] dividend;
		logic [39:0] divisor;
	} ds_req_t;

	typedef enum logic [5:0] {
		S_IDLE, S_SMP, S_SFIN, S_DONE,
		S_H, S_HW,
		S_ED, S_EDD, S_EX, S_EAL, S_EAH, S_EXX,
		S_ET1, S_ET2, S_ET3, S_EW1, S_EW2, S_EWR,
		S_CR1, S_CR2, S_CR3, S_CP, S_CPH, S_CIN, S_CC, S_CCF,
		S_CS1, S_CS2, S_CS3, S_CS4,
		S_CFIN, S_CSQ, S_CDV, S_CWR
	} seq_st_t;

endpackage

`default_nettype wire

@@ design/gcts_divsqrt.sv @@
// ---------------------------------------------------------------------------
// gcts_divsqrt
// Shared iterative unit: unsigned restoring division (one bit per cycle)
// or integer square root (two bits per cycle).
// ---------------------------------------------------------------------------
`default_nettype none

module gcts_divsqrt (
	input  wire                    clk,
	input  wire                    arst_n,
	input  gcts_pkg::ds_req_t      req,
	output logic                   done,
	output logic [63:0]            quo
);
	import gcts_pkg::*;

	logic        busy_q;
	logic [6:0]  cnt_q;
	logic        done_q;
	logic        sq_q;
	logic [63:0] dv_q;
	logic [63:0] quo_q;
	logic [40:0] rem_q;
	logic [39:0] dsr_q;
	logic [40:0] r1;
	logic [40:0] trial;
	logic [40:0] rem_n;
	logic        ge;

	always_comb begin
		if (sq_q) begin
			r1    = {rem_q[38:0], dv_q[63:62]};
			trial = {quo_q[38:0], 2'b01};
		end else begin
			r1    = {rem_q[39:0], dv_q[63]};
			trial = {1'b0, dsr_q};
		end
		ge    = (r1 >= trial);
		rem_n = ge ? (r1 - trial) : r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.is_sqrt ? 7'd32 : 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sq_q  <= req.is_sqrt;
			dv_q  <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[62:0], ge};
			dv_q  <= sq_q ? {dv_q[61:0], 2'b00} : {dv_q[62:0], 1'b0};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

@@ design/gcts_seq.sv @@
// ---------------------------------------------------------------------------
// gcts_seq
// Sequencer around the factor and variate memories and one shared
// multiplier: builds the Cholesky factor and forms the sample dot products.
// ---------------------------------------------------------------------------
`default_nettype none

module gcts_seq #(
	parameter int MAX_STEPS = gcts_pkg::MAX_STEPS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  gcts_pkg::cfg_t         cfg,
	input  wire                    cfg_wr,
	input  wire                    start,
	input  gcts_pkg::op_t          op,
	input  wire  [15:0]            variate,
	input  wire                    out_free,
	output logic                   idle,
	output logic                   res_load,
	output gcts_pkg::res_t         res,
	output gcts_pkg::ds_req_t      ds_req,
	input  wire                    ds_done,
	input  wire  [63:0]            ds_quo
);
	import gcts_pkg::*;

	localparam int IW     = $clog2(MAX_STEPS);
	localparam int NW     = $clog2(MAX_STEPS + 1);
	localparam int AW     = 2 * IW;
	localparam int FDEPTH = 1 << AW;
	localparam int VDEPTH = 1 << IW;

	localparam logic signed [55:0] Y_MAX   = 56'sd2147483647;
	localparam logic signed [55:0] Y_MIN   = -56'sd2147483648;
	localparam logic signed [55:0] ACC_LIM = 56'sd4294967296;

	seq_st_t st_q, st_d;

	logic          ready_q;
	logic [IW-1:0] pos_q, i_q, j_q, k_q, m_q;
	logic [NW-1:0] n;
	logic [IW-1:0] nl;

	logic [30:0]   h_q;
	logic [39:0]   x_q;
	logic [55:0]   t_q;
	logic [4:0]    whole_q;
	logic [15:0]   frac_q;
	logic [30:0]   term_q;
	logic [31:0]   es_q;
	logic [3:0]    kk_q;
	logic          rz_q;
	logic [31:0]   ei_q, ej_q, ed_q;
	logic [30:0]   p_q;
	logic signed [32:0] inner_q;
	logic signed [55:0] acc_q;
	logic [31:0]   la_q;
	logic [30:0]   ljj_q;
	logic [31:0]   val_q;
	logic          neg_q;
	logic          iss_q, v1_s1, v2_s2;
	res_t          res_q;

	logic [31:0]   fmem [0:FDEPTH-1];
	logic [31:0]   frd_q;
	logic          fwe;
	logic [AW-1:0] fwa, fra;
	logic [31:0]   fwd;
	logic [15:0]   vmem [0:VDEPTH-1];
	logic [15:0]   vrd_q;
	logic          vwe;
	logic [IW-1:0] vra;

	logic signed [32:0] ma, mb;
	logic signed [65:0] mp_q;

	logic [31:0]   emux;
	logic [63:0]   prod64;
	logic [47:0]   xx;
	logic [43:0]   xfull;
	logic [39:0]   x_n;
	logic signed [55:0] ysh;
	logic signed [55:0] accc;
	logic [32:0]   mag;
	logic          last_row, last_col;

	always_comb begin
		if (cfg.steps < 5'd2) begin
			n = NW'(2);
		end else if (int'(cfg.steps) > MAX_STEPS) begin
			n = NW'(MAX_STEPS);
		end else begin
			n = NW'(cfg.steps);
		end
		nl = IW'(n - NW'(1));
	end

	assign emux   = rz_q ? ONE_Q30 : frd_q;
	assign prod64 = {mp_q[31:0], 32'd0} + {8'd0, t_q};
	assign xx     = prod64[63:16];
	assign xfull  = mp_q[59:16];
	assign x_n    = (xfull > 44'h080_0000_0000) ? 40'h80_0000_0000 : xfull[39:0];
	assign ysh    = acc_q >>> 26;
	assign last_row = (i_q == nl);
	assign last_col = (j_q == nl);

	always_comb begin
		if (acc_q > ACC_LIM) begin
			accc = ACC_LIM;
		end else if (acc_q < -ACC_LIM) begin
			accc = -ACC_LIM;
		end else begin
			accc = acc_q;
		end
		mag = acc_q[55] ? 33'(-accc) : 33'(accc);
	end

	// memories
	always_ff @(posedge clk) begin
		if (fwe) begin
			fmem[fwa] <= fwd;
		end
		frd_q <= fmem[fra];
	end

	always_ff @(posedge clk) begin
		if (vwe) begin
			vmem[pos_q] <= variate;
		end
		vrd_q <= vmem[vra];
	end

	always_ff @(posedge clk) begin
		mp_q <= ma * mb;
	end

	// next state and datapath controls
	always_comb begin
		st_d     = st_q;
		fra      = '0;
		vra      = j_q;
		fwe      = 1'b0;
		fwa      = {i_q, j_q};
		fwd      = val_q;
		vwe      = 1'b0;
		ma       = '0;
		mb       = '0;
		ds_req   = '0;
		res_load = 1'b0;
		unique case (st_q)
			S_IDLE: begin
				if (start) begin
					if (op == OP_BUILD) begin
						st_d = S_H;
					end else if (!ready_q) begin
						st_d = S_DONE;
					end else begin
						vwe  = 1'b1;
						st_d = S_SMP;
					end
				end
			end
			S_SMP: begin
				fra = {pos_q, j_q};
				ma  = $signed({frd_q[31], frd_q});
				mb  = $signed({{17{vrd_q[15]}}, vrd_q});
				if (!iss_q && !v1_s1 && !v2_s2) begin
					st_d = S_SFIN;
				end
			end
			S_SFIN: st_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					res_load = 1'b1;
					st_d     = S_IDLE;
				end
			end
			S_H: begin
				ds_req.start    = 1'b1;
				ds_req.dividend = 64'(NOISE_Q30) << 30;
				ds_req.divisor  = {2'b00, cfg.scale, 14'd0} + NOISE_Q30;
				st_d            = S_HW;
			end
			S_HW: begin
				if (ds_done) begin
					st_d = S_ED;
				end
			end
			S_ED: begin
				ma   = $signed(33'(m_q));
				mb   = $signed({9'd0, cfg.dt});
				st_d = S_EDD;
			end
			S_EDD: begin
				ma   = $signed({3'd0, mp_q[29:0]});
				mb   = $signed({3'd0, mp_q[29:0]});
				st_d = S_EX;
			end
			S_EX: st_d = S_EAL;
			S_EAL: begin
				ma   = $signed({1'b0, x_q[31:0]});
				mb   = $signed({9'd0, cfg.sharp});
				st_d = S_EAH;
			end
			S_EAH: begin
				ma   = $signed({25'd0, x_q[39:32]});
				mb   = $signed({9'd0, cfg.sharp});
				st_d = S_EXX;
			end
			S_EXX: st_d = (xx >= EXP_CUT) ? S_EWR : S_ET1;
			S_ET1: begin
				ma   = $signed({2'b00, term_q});
				mb   = $signed({17'd0, frac_q});
				st_d = S_ET2;
			end
			S_ET2: begin
				ds_req.start    = 1'b1;
				ds_req.dividend = {34'd0, mp_q[45:16]};
				ds_req.divisor  = {36'd0, kk_q};
				st_d            = S_ET3;
			end
			S_ET3: begin
				if (ds_done) begin
					st_d = (kk_q == TAYLOR_N) ? S_EW1 : S_ET1;
				end
			end
			S_EW1: begin
				ma = $signed({1'b0, es_q});
				mb = $signed({1'b0, EXP_M1_Q30});
				st_d = (whole_q == 5'd0) ? S_EWR : S_EW2;
			end
			S_EW2: st_d = S_EW1;
			S_EWR: begin
				fwe  = 1'b1;
				fwa  = {IW'(0), m_q};
				fwd  = es_q;
				st_d = (m_q == nl) ? S_CR1 : S_ED;
			end
			S_CR1: begin
				fra  = {IW'(0), i_q};
				st_d = S_CR2;
			end
			S_CR2: begin
				fra  = {IW'(0), j_q};
				st_d = S_CR3;
			end
			S_CR3: begin
				fra  = {IW'(0), IW'(i_q - j_q)};
				st_d = S_CP;
			end
			S_CP: begin
				ma   = $signed({1'b0, ei_q});
				mb   = $signed({1'b0, ej_q});
				st_d = S_CPH;
			end
			S_CPH: begin
				ma   = $signed({2'b00, mp_q[60:30]});
				mb   = $signed({2'b00, h_q});
				st_d = S_CIN;
			end
			S_CIN: st_d = S_CC;
			S_CC: begin
				ma   = inner_q;
				mb   = $signed({9'd0, cfg.scale});
				st_d = S_CCF;
			end
			S_CCF: st_d = (j_q == IW'(0)) ? S_CFIN : S_CS1;
			S_CS1: begin
				fra  = {i_q, k_q};
				st_d = S_CS2;
			end
			S_CS2: begin
				fra  = {j_q, k_q};
				st_d = S_CS3;
			end
			S_CS3: begin
				ma   = $signed({la_q[31], la_q});
				mb   = $signed({frd_q[31], frd_q});
				st_d = S_CS4;
			end
			S_CS4: st_d = (IW'(k_q + IW'(1)) == j_q) ? S_CFIN : S_CS1;
			S_CFIN: begin
				if (i_q == j_q) begin
					if (acc_q <= 56'sd0) begin
						st_d = S_DONE;
					end else if (acc_q >= ACC_LIM) begin
						st_d = S_CWR;
					end else begin
						ds_req.start    = 1'b1;
						ds_req.is_sqrt  = 1'b1;
						ds_req.dividend = {2'b00, acc_q[31:0], 30'd0};
						st_d            = S_CSQ;
					end
				end else begin
					ds_req.start    = 1'b1;
					ds_req.dividend = {1'b0, mag, 30'd0};
					ds_req.divisor  = {9'd0, ljj_q};
					st_d            = S_CDV;
				end
			end
			S_CSQ: begin
				if (ds_done) begin
					st_d = S_CWR;
				end
			end
			S_CDV: begin
				if (ds_done) begin
					st_d = S_CWR;
				end
			end
			S_CWR: begin
				fwe = 1'b1;
				if (last_row && last_col) begin
					st_d = S_DONE;
				end else begin
					st_d = S_CR1;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			ready_q <= 1'b0;
			pos_q   <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_wr) begin
				ready_q <= 1'b0;
				pos_q   <= '0;
			end else begin
				case (st_q)
					S_IDLE: begin
						if (start && op == OP_BUILD) begin
							ready_q <= 1'b0;
							pos_q   <= '0;
						end
					end
					S_SFIN: pos_q <= (pos_q == nl) ? '0 : IW'(pos_q + IW'(1));
					S_CWR: begin
						if (last_row && last_col) begin
							ready_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				res_q.value <= '0;
				res_q.step  <= '0;
				res_q.last  <= 1'b0;
				res_q.status <= (op == OP_SAMPLE && !ready_q) ? STS_NOFACT : STS_OK;
				j_q   <= '0;
				acc_q <= '0;
				iss_q <= 1'b1;
				v1_s1 <= 1'b0;
				v2_s2 <= 1'b0;
				m_q   <= IW'(1);
			end
			S_SMP: begin
				v1_s1 <= iss_q;
				v2_s2 <= v1_s1;
				if (iss_q) begin
					if (j_q == pos_q) begin
						iss_q <= 1'b0;
					end else begin
						j_q <= IW'(j_q + IW'(1));
					end
				end
				if (v2_s2) begin
					acc_q <= acc_q + 56'(mp_q);
				end
			end
			S_SFIN: begin
				if (ysh > Y_MAX) begin
					res_q.value <= Q30_MAX;
				end else if (ysh < Y_MIN) begin
					res_q.value <= Q30_MIN;
				end else begin
					res_q.value <= ysh[31:0];
				end
				res_q.step <= 4'(pos_q);
				res_q.last <= (pos_q == nl);
			end
			S_HW: begin
				if (ds_done) begin
					h_q <= ds_quo[30:0];
				end
			end
			S_EX: x_q <= x_n;
			S_EAH: t_q <= mp_q[55:0];
			S_EXX: begin
				whole_q <= xx[20:16];
				frac_q  <= xx[15:0];
				term_q  <= ONE_Q30[30:0];
				es_q    <= (xx >= EXP_CUT) ? 32'd0 : ONE_Q30;
				kk_q    <= 4'd1;
			end
			S_ET3: begin
				if (ds_done) begin
					term_q <= {1'b0, ds_quo[29:0]};
					es_q   <= kk_q[0] ? es_q - {2'b00, ds_quo[29:0]}
					                  : es_q + {2'b00, ds_quo[29:0]};
					kk_q   <= kk_q + 4'd1;
				end
			end
			S_EW2: begin
				es_q    <= {1'b0, mp_q[60:30]};
				whole_q <= whole_q - 5'd1;
			end
			S_EWR: begin
				m_q <= IW'(m_q + IW'(1));
				i_q <= '0;
				j_q <= '0;
			end
			S_CR1: rz_q <= (i_q == IW'(0));
			S_CR2: begin
				ei_q <= emux;
				rz_q <= (j_q == IW'(0));
			end
			S_CR3: begin
				ej_q <= emux;
				rz_q <= (i_q == j_q);
			end
			S_CP: ed_q <= emux;
			S_CPH: p_q <= mp_q[60:30];
			S_CIN: inner_q <= $signed({1'b0, ed_q}) - $signed({2'b00, p_q})
			                  + $signed({2'b00, mp_q[60:30]});
			S_CCF: begin
				acc_q <= 56'(mp_q >>> 16);
				k_q   <= '0;
			end
			S_CS2: la_q <= frd_q;
			S_CS4: begin
				acc_q <= acc_q - 56'(mp_q >>> 30);
				k_q   <= IW'(k_q + IW'(1));
			end
			S_CFIN: begin
				neg_q <= acc_q[55];
				val_q <= Q30_MAX;
				if (i_q == j_q && acc_q <= 56'sd0) begin
					res_q.status <= STS_NPD;
				end
			end
			S_CSQ: begin
				if (ds_done) begin
					val_q <= ds_quo[31:0];
				end
			end
			S_CDV: begin
				if (ds_done) begin
					if (neg_q) begin
						val_q <= (ds_quo > 64'h8000_0000) ? Q30_MIN : 32'(-ds_quo);
					end else begin
						val_q <= (ds_quo > 64'h7fff_ffff) ? Q30_MAX : ds_quo[31:0];
					end
				end
			end
			S_CWR: begin
				if (i_q == j_q) begin
					ljj_q <= val_q[30:0];
				end
				if (last_row) begin
					j_q <= IW'(j_q + IW'(1));
					i_q <= IW'(j_q + IW'(1));
				end else begin
					i_q <= IW'(i_q + IW'(1));
				end
			end
			default: ;
		endcase
	end

	assign idle = (st_q == S_IDLE);
	assign res  = res_q;

endmodule

`default_nettype wire

@@ design/gp_cholesky_trajectory_sampler_core.sv @@
// ---------------------------------------------------------------------------
// gp_cholesky_trajectory_sampler_core
// Gaussian-process trajectory sampler: builds the lower Cholesky factor of a
// conditioned squared-exponential covariance and correlates normal variates.
// ---------------------------------------------------------------------------
// One item is processed at a time; s_tready is high while the sequencer is
// idle, and a finished result waits in the output register so the next item
// can already start. A sample transfer for step k does one factor/variate
// memory read and one multiply per term through a short pipeline. A build
// transfer runs the shared divider for the Taylor terms and off-diagonal
// quotients and the square root of each pivot. Every result carries a
// status in m_tuser; a sample needs a successful build after the last
// register write.
`default_nettype none

module gp_cholesky_trajectory_sampler_core #(
	parameter int MAX_STEPS = gcts_pkg::MAX_STEPS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // [15:0] variate
	input  wire         s_tuser,   // [0] op
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // [31:0] sample_value, [35:32] step_index
	output logic        m_tlast,
	output logic [1:0]  m_tuser,   // [1:0] status
	input  wire         cfg_wr_en,
	input  wire  [1:0]  cfg_index,
	input  wire  [23:0] cfg_wdata
);
	import gcts_pkg::*;

	cfg_t    cfg_q;
	res_t    out_q;
	logic    out_valid_q;
	logic    idle;
	logic    res_load;
	logic    out_free;
	res_t    res;
	ds_req_t ds_req;
	logic    ds_done;
	logic [63:0] ds_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sharp <= SHARP_RST;
			cfg_q.scale <= SCALE_RST;
			cfg_q.dt    <= DT_RST;
			cfg_q.steps <= STEPS_RST;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SHARP: cfg_q.sharp <= cfg_wdata;
				REG_SCALE: cfg_q.scale <= cfg_wdata;
				REG_DT:    cfg_q.dt    <= cfg_wdata;
				REG_STEPS: cfg_q.steps <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res;
		end
	end

	gcts_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ds_req),
		.done   (ds_done),
		.quo    (ds_quo)
	);

	gcts_seq #(
		.MAX_STEPS (MAX_STEPS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cfg_wr   (cfg_wr_en),
		.start    (s_tvalid && idle),
		.op       (op_t'(s_tuser)),
		.variate  (s_tdata),
		.out_free (out_free),
		.idle     (idle),
		.res_load (res_load),
		.res      (res),
		.ds_req   (ds_req),
		.ds_done  (ds_done),
		.ds_quo   (ds_quo)
	);

	assign s_tready = idle;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_q.step, out_q.value};
	assign m_tlast  = out_q.last;
	assign m_tuser  = out_q.status;

endmodule

`default_nettype wire

@@ design/gcts_checker.sv @@
// ---------------------------------------------------------------------------
// gcts_checker
// Port-level checks of the trajectory sampler, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module gcts_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [15:0] s_tdata,
	input wire        s_tuser,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [39:0] m_tdata,
	input wire        m_tlast,
	input wire [1:0]  m_tuser,
	input wire        cfg_wr_en,
	input wire [1:0]  cfg_index,
	input wire [23:0] cfg_wdata
);
	import gcts_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output transfer changed");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	a_err_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STS_OK |-> m_tdata[35:0] == 36'd0 && !m_tlast)
		else $error("failed result carries a value");

	a_last_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == STS_OK)
		else $error("last step without ok status");

endmodule

bind gp_cholesky_trajectory_sampler_core gcts_checker u_gcts_checker (.*);

`default_nettype wire
